// ----- design/tinted_pixel_blend_over_top_macros.svh -----
// Assertion macros of the tinted pixel blend pipeline control.
`ifndef TINTED_PIXEL_BLEND_OVER_TOP_MACROS_SVH
`define TINTED_PIXEL_BLEND_OVER_TOP_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define TPBO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent holds in the following cycle.
`define TPBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tpbo_pkg.sv -----
// Shared types, constants and arithmetic helpers of the tinted pixel blender.
package tpbo_pkg;

  localparam int unsigned ChW       = 8;
  localparam int unsigned NumCh     = 4;
  localparam int unsigned PixW      = ChW * NumCh;
  localparam int unsigned TintW     = 16;
  localparam int unsigned ProdW     = ChW + TintW;
  localparam int unsigned NumStages = 5;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [ChW-1:0]   ChMax     = 8'hFF;
  localparam logic [ProdW-1:0] TintSat   = 24'd65280;
  localparam logic [15:0]      TintHalf  = 16'd128;
  localparam logic [TintW-1:0] TintOne   = 16'd256;
  // x / 255 equals (x * 32897) >> 23 for every 16-bit x.
  localparam logic [15:0]      Div255Mul = 16'd32897;

  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;
  localparam int unsigned ChAlpha = 3;

  localparam logic [CfgIdxW-1:0] RegTintRed   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTintGreen = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTintBlue  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTintAlpha = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlendEn   = 3'd4;

  typedef logic [NumCh-1:0][TintW-1:0] tint_set_t;

  // Stage enables handed from the pipeline control to the datapath.
  typedef struct packed {
    logic [NumStages-1:0] en;
  } ctrl_t;

  // Round a tint product to nearest and saturate at full scale.
  function automatic logic [ChW-1:0] tint_round(input logic [ProdW-1:0] p);
    logic [15:0] sum;
    sum = p[15:0] + TintHalf;
    if (p >= TintSat) begin
      return ChMax;
    end
    return sum[15:8];
  endfunction

  // Exact division by 255 of a 16-bit value below 65280, whose quotient fits in eight bits.
  function automatic logic [ChW-1:0] div255(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'(Div255Mul);
    return prod[30:23];
  endfunction

endpackage

// ----- design/tinted_pixel_blend_over_top.sv -----
// Top level of the tinted source-over pixel blender.
//
// One word on the input channel carries a source and a destination RGBA8
// pixel (red in the low byte). Each source channel is scaled by its Q8.8
// tint, rounded and saturated, and the result is composited over the
// destination; one blended pixel leaves on the output channel per word.
// Both channels use valid/ready and a word moves when both are high.
// The pipeline has five register stages: tint multiply, round/saturate,
// weighted sums, division by 255 through a reciprocal multiply, and the
// final select with alpha saturation. While the receiver is ready, a new
// word is taken every cycle.
// Each stage holds its word while the next one is full, so when the
// receiver stalls the pipeline fills its bubbles and only then drops
// in_ready_o; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the tint registers with
// 1.0 and blending enabled. The configuration port writes one register
// per cycle with write enable high; indexes past the list are ignored.
// Registers should only be written while no word is in flight.
module tinted_pixel_blend_over_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tpbo_pkg::PixW-1:0]    source_pixel_i,
  input  logic [tpbo_pkg::PixW-1:0]    dest_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tpbo_pkg::PixW-1:0]    blended_pixel_o,
  input  logic                         cfg_we_i,
  input  logic [tpbo_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tpbo_pkg::TintW-1:0]   cfg_data_i
);

  tpbo_pkg::tint_set_t tint_q, tint_d;
  logic blend_q, blend_d;
  tpbo_pkg::ctrl_t ctrl;
  logic [tpbo_pkg::PixW-1:0] tinted, dst_tint;

  // Register file; unknown indexes leave everything unchanged.
  always_comb begin
    tint_d  = tint_q;
    blend_d = blend_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tpbo_pkg::RegTintRed:   tint_d[tpbo_pkg::ChRed]   = cfg_data_i;
        tpbo_pkg::RegTintGreen: tint_d[tpbo_pkg::ChGreen] = cfg_data_i;
        tpbo_pkg::RegTintBlue:  tint_d[tpbo_pkg::ChBlue]  = cfg_data_i;
        tpbo_pkg::RegTintAlpha: tint_d[tpbo_pkg::ChAlpha] = cfg_data_i;
        tpbo_pkg::RegBlendEn:   blend_d = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q  <= {tpbo_pkg::NumCh{tpbo_pkg::TintOne}};
      blend_q <= 1'b1;
    end else begin
      tint_q  <= tint_d;
      blend_q <= blend_d;
    end
  end

  tpbo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  tpbo_tint u_tint (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .tint_i     (tint_q),
    .blend_en_i (blend_q),
    .src_i      (source_pixel_i),
    .dst_i      (dest_pixel_i),
    .tinted_o   (tinted),
    .dst_o      (dst_tint)
  );

  tpbo_mix u_mix (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .tinted_i (tinted),
    .dst_i    (dst_tint),
    .result_o (blended_pixel_o)
  );

endmodule

// ----- design/tpbo_ctrl.sv -----
// Valid tracking and per-stage enables of the blend pipeline.
`include "tinted_pixel_blend_over_top_macros.svh"
module tpbo_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tpbo_pkg::ctrl_t ctrl_o
);

  logic [tpbo_pkg::NumStages-1:0] valid_q, valid_d, en;

  // A stage may load when it is empty or its word moves on this cycle.
  always_comb begin
    en[tpbo_pkg::NumStages-1] = !valid_q[tpbo_pkg::NumStages-1] || out_ready_i;
    for (int k = tpbo_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < tpbo_pkg::NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[tpbo_pkg::NumStages-1];
  assign ctrl_o.en   = en;

  `TPBO_ASSERT_NEXT(a_accept_fills, in_valid_i && en[0], valid_q[0], "accepted word lost")
  `TPBO_ASSERT_NEXT(a_stage_holds, valid_q[1] && !en[1], valid_q[1], "stalled stage dropped")
  `TPBO_ASSERT_NOW(a_ready_bubble, out_valid_o && !out_ready_i && en[0], !(&valid_q),
                   "ready while pipeline full and stalled")

endmodule

// ----- design/tpbo_tint.sv -----
// Tint stages: per-channel Q8.8 multiply, then round and saturate (alpha forced opaque with blending off).
module tpbo_tint (
  input  logic                          clk_i,
  input  tpbo_pkg::ctrl_t               ctrl_i,
  input  tpbo_pkg::tint_set_t           tint_i,
  input  logic                          blend_en_i,
  input  logic [tpbo_pkg::PixW-1:0]     src_i,
  input  logic [tpbo_pkg::PixW-1:0]     dst_i,
  output logic [tpbo_pkg::PixW-1:0]     tinted_o,
  output logic [tpbo_pkg::PixW-1:0]     dst_o
);

  logic [tpbo_pkg::NumCh-1:0][tpbo_pkg::ProdW-1:0] prod_d, prod_q;
  logic [tpbo_pkg::PixW-1:0] dst1_q, tinted_d, tinted_q, dst2_q;
  logic blend1_q;

  always_comb begin
    for (int c = 0; c < tpbo_pkg::NumCh; c++) begin
      prod_d[c] = tpbo_pkg::ProdW'(src_i[c*tpbo_pkg::ChW +: tpbo_pkg::ChW]) *
                  tpbo_pkg::ProdW'(tint_i[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < tpbo_pkg::NumCh; c++) begin
      tinted_d[c*tpbo_pkg::ChW +: tpbo_pkg::ChW] = tpbo_pkg::tint_round(prod_q[c]);
    end
    // With blending off the source is treated as fully opaque.
    if (!blend1_q) begin
      tinted_d[tpbo_pkg::ChAlpha*tpbo_pkg::ChW +: tpbo_pkg::ChW] = tpbo_pkg::ChMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      prod_q   <= prod_d;
      dst1_q   <= dst_i;
      blend1_q <= blend_en_i;
    end
    if (ctrl_i.en[1]) begin
      tinted_q <= tinted_d;
      dst2_q   <= dst1_q;
    end
  end

  assign tinted_o = tinted_q;
  assign dst_o    = dst2_q;

endmodule

// ----- design/tpbo_mix.sv -----
// Source-over stages: weighted sums, division by 255, and final select.
module tpbo_mix (
  input  logic                      clk_i,
  input  tpbo_pkg::ctrl_t           ctrl_i,
  input  logic [tpbo_pkg::PixW-1:0] tinted_i,
  input  logic [tpbo_pkg::PixW-1:0] dst_i,
  output logic [tpbo_pkg::PixW-1:0] result_o
);

  localparam int unsigned W = tpbo_pkg::ChW;

  logic [tpbo_pkg::NumCh-1:0][15:0] sum_d, sum_q;
  logic [tpbo_pkg::PixW-1:0] src3_q, dst3_q, src4_q, dst4_q, quot_d, quot_q;
  logic [tpbo_pkg::PixW-1:0] result_d, result_q;
  logic [W-1:0] sa, inv_sa, sa4;
  logic [W:0]   alpha_sum;

  assign sa     = tinted_i[tpbo_pkg::ChAlpha*W +: W];
  assign inv_sa = tpbo_pkg::ChMax - sa;

  always_comb begin
    for (int c = 0; c < tpbo_pkg::NumCh - 1; c++) begin
      sum_d[c] = 16'(tinted_i[c*W +: W]) * 16'(sa) + 16'(dst_i[c*W +: W]) * 16'(inv_sa);
    end
    // Destination alpha weighted by the uncovered fraction.
    sum_d[tpbo_pkg::ChAlpha] = 16'(dst_i[tpbo_pkg::ChAlpha*W +: W]) * 16'(inv_sa);
  end

  always_comb begin
    for (int c = 0; c < tpbo_pkg::NumCh; c++) begin
      quot_d[c*W +: W] = tpbo_pkg::div255(sum_q[c]);
    end
  end

  assign sa4       = src4_q[tpbo_pkg::ChAlpha*W +: W];
  assign alpha_sum = (W+1)'(sa4) + (W+1)'(quot_q[tpbo_pkg::ChAlpha*W +: W]);

  always_comb begin
    if (sa4 == '0) begin
      result_d = dst4_q;
    end else if (sa4 == tpbo_pkg::ChMax) begin
      result_d = src4_q;
    end else begin
      result_d = quot_q;
      result_d[tpbo_pkg::ChAlpha*W +: W] = alpha_sum[W] ? tpbo_pkg::ChMax : alpha_sum[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      sum_q  <= sum_d;
      src3_q <= tinted_i;
      dst3_q <= dst_i;
    end
    if (ctrl_i.en[3]) begin
      quot_q <= quot_d;
      src4_q <= src3_q;
      dst4_q <= dst3_q;
    end
    if (ctrl_i.en[4]) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule
